// ===== src/ptts_pkg.sv =====
package ptts_pkg;

    // Operation codes carried on the operation field
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_CREATE  = 3'd1;
    localparam logic [2:0] OP_DELETE  = 3'd2;
    localparam logic [2:0] OP_SUSPEND = 3'd3;
    localparam logic [2:0] OP_RESUME  = 3'd4;

    localparam int TIME_W = 16;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_RMW    = 5'b00100,
        ST_EMIT   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

endpackage

// ===== src/periodic_task_tick_scheduler.sv =====
// Channel  Handshake            Payload
// -------  -------------------  ----------------------------------------
// input    in_valid / in_ready  operation, slot, period, first_delay
// output   out_valid / out_ready fired, run_index, last
//
// Create, delete, suspend and resume update the tables on acceptance;
// the acknowledgement is loaded in the finish state once the output
// register has space. A tick walks the slot table once: a scan step per
// slot, an RMW step per valid running slot (timer RAM read, then
// write-back), an emit step per due slot after the first and a finish
// step to close. The walk only halts when a result must be pushed while
// the output register is still full. Reset clears the valid and running
// marks; the timer RAM needs no clearing, only created slots use it.
module periodic_task_tick_scheduler
    import ptts_pkg::*;
#(
    parameter int TASK_COUNT = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [2:0]  slot,
    input  logic [15:0] period,
    input  logic [15:0] first_delay,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        fired,
    output logic [2:0]  run_index,
    output logic        last
);

    localparam int IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_COUNT - 1);
    localparam int RAM_W = 2 * TIME_W;

    // Sequencer
    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;

    // Pending due slot: held back until we know whether it is the final one
    logic                held_valid_reg, held_valid_next;
    logic [IDX_W-1:0]    held_idx_reg, held_idx_next;
    logic [IDX_W-1:0]    cand_idx_reg, cand_idx_next;

    // Per-slot marks in flops
    logic [TASK_COUNT-1:0] valid_marks_reg, valid_marks_next;
    logic [TASK_COUNT-1:0] running_marks_reg, running_marks_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic                fired_reg, fired_next;
    logic [2:0]          run_index_reg, run_index_next;
    logic                last_reg, last_next;

    // Timer RAM: {period, countdown} per slot
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [RAM_W-1:0]    ram_wdata;
    logic [RAM_W-1:0]    ram_rdata;

    logic                in_fire;
    logic                out_space;
    logic [IDX_W+2:0]    slot_wide;
    logic [IDX_W-1:0]    slot_addr;
    logic                slot_in_range;
    logic [IDX_W+2:0]    held_wide;
    logic [2:0]          held_run_index;
    logic [TIME_W-1:0]   rd_period;
    logic [TIME_W-1:0]   rd_count;
    logic                rd_due;
    logic [TIME_W-1:0]   count_upd;
    logic                scan_done;
    logic                slot_active;

    ptts_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TASK_COUNT)
    ) u_timer_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_space = !out_valid_reg || out_ready;

    assign slot_wide     = {{IDX_W{1'b0}}, slot};
    assign slot_addr     = slot_wide[IDX_W-1:0];
    assign slot_in_range = ({29'd0, slot} < 32'(TASK_COUNT));

    // Only slots below eight can be created, so the low three bits suffice
    assign held_wide      = {3'b000, held_idx_reg};
    assign held_run_index = held_wide[2:0];

    assign rd_period = ram_rdata[RAM_W-1:TIME_W];
    assign rd_count  = ram_rdata[TIME_W-1:0];
    assign rd_due    = (rd_count == '0);
    // Reload wraps to all ones for a zero period
    assign count_upd = rd_due ? (rd_period - TIME_W'(1)) : (rd_count - TIME_W'(1));

    assign scan_done   = (idx_reg == LAST_IDX);
    assign slot_active = valid_marks_reg[idx_reg] && running_marks_reg[idx_reg];

    always_comb
    begin
        state_next         = state_reg;
        idx_next           = idx_reg;
        held_valid_next    = held_valid_reg;
        held_idx_next      = held_idx_reg;
        cand_idx_next      = cand_idx_reg;
        valid_marks_next   = valid_marks_reg;
        running_marks_next = running_marks_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        fired_next         = fired_reg;
        run_index_next     = run_index_reg;
        last_next          = last_reg;
        ram_we             = 1'b0;
        ram_waddr          = idx_reg;
        ram_wdata          = {rd_period, count_upd};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    held_valid_next = 1'b0;
                    if (operation == OP_TICK)
                    begin
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                        if (slot_in_range)
                        begin
                            unique case (operation)
                                OP_CREATE:
                                begin
                                    valid_marks_next[slot_addr]   = 1'b1;
                                    running_marks_next[slot_addr] = 1'b1;
                                    ram_we    = 1'b1;
                                    ram_waddr = slot_addr;
                                    ram_wdata = {period, first_delay};
                                end
                                OP_DELETE:  valid_marks_next[slot_addr]   = 1'b0;
                                OP_SUSPEND: running_marks_next[slot_addr] = 1'b0;
                                OP_RESUME:  running_marks_next[slot_addr] = 1'b1;
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                if (slot_active)
                begin
                    state_next = ST_RMW;
                end
                else if (scan_done)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            ST_RMW:
            begin
                // Only one slot is in flight, so no write-back can meet its read
                ram_we = 1'b1;
                if (rd_due && held_valid_reg)
                begin
                    cand_idx_next = idx_reg;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    if (rd_due)
                    begin
                        held_valid_next = 1'b1;
                        held_idx_next   = idx_reg;
                    end
                    if (scan_done)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_EMIT:
            begin
                if (out_space)
                begin
                    out_valid_next = 1'b1;
                    fired_next     = 1'b1;
                    run_index_next = held_run_index;
                    last_next      = 1'b0;
                    held_idx_next  = cand_idx_reg;
                    if (scan_done)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_FINISH:
            begin
                if (out_space)
                begin
                    out_valid_next  = 1'b1;
                    fired_next      = held_valid_reg;
                    run_index_next  = held_valid_reg ? held_run_index : 3'd0;
                    last_next       = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            idx_reg           <= '0;
            held_valid_reg    <= 1'b0;
            valid_marks_reg   <= '0;
            running_marks_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            idx_reg           <= idx_next;
            held_valid_reg    <= held_valid_next;
            valid_marks_reg   <= valid_marks_next;
            running_marks_reg <= running_marks_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_idx_reg  <= held_idx_next;
        cand_idx_reg  <= cand_idx_next;
        fired_reg     <= fired_next;
        run_index_reg <= run_index_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign fired     = fired_reg;
    assign run_index = run_index_reg;
    assign last      = last_reg;

    // A second due slot is only parked while an earlier one is held
    a_emit_has_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> held_valid_reg)
        else $error("emit without a held due slot");

    // Read-modify-write only visits slots that are valid and running
    a_rmw_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RMW) |-> slot_active)
        else $error("timer update on an inactive slot");

    // A non-tick transaction goes straight to its acknowledgement
    a_ack_path: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && operation != OP_TICK) |=> (state_reg == ST_FINISH && !held_valid_reg))
        else $error("non-tick transaction did not head for acknowledgement");

    // Every pushed result that is not final names a due slot
    a_nonfinal_fired: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> fired_reg)
        else $error("non-final result without a due slot");

endmodule

// ===== src/ptts_ram.sv =====
module ptts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sim/tb_periodic_task_tick_scheduler.sv =====
module tb_periodic_task_tick_scheduler;

    timeunit 1ns;
    timeprecision 1ps;

    import ptts_pkg::*;

    localparam int TASK_COUNT = 8;

    // Codes outside the defined set: the block must just acknowledge them
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // Percentage of cycles in which either side holds off
    localparam int IDLE_PCT = 36;

    // Fired results, acks and idle ticks all share this shape
    typedef struct packed {
        logic       fired;
        logic [2:0] run_index;
        logic       last;
    } sched_result_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [2:0]  operation   = OP_TICK;
    logic [2:0]  slot        = 3'd0;
    logic [15:0] period      = 16'd0;
    logic [15:0] first_delay = 16'd0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic        fired;
    logic [2:0]  run_index;
    logic        last;

    // Mirror of the task table
    logic        task_valid   [TASK_COUNT];
    logic        task_running [TASK_COUNT];
    logic [15:0] task_period  [TASK_COUNT];
    logic [15:0] task_count   [TASK_COUNT];

    // Results still owed by the block, oldest first
    sched_result_t pending_results[$];
    sched_result_t want;
    sched_result_t got;

    bit sender_idle_en = 1'b1;
    bit sink_stall_en  = 1'b1;

    int items_sent   = 0;
    int results_seen = 0;
    int fired_seen   = 0;
    int ticks_sent   = 0;
    int mismatches   = 0;

    periodic_task_tick_scheduler #(
        .TASK_COUNT (TASK_COUNT)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .slot        (slot),
        .period      (period),
        .first_delay (first_delay),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .fired       (fired),
        .run_index   (run_index),
        .last        (last)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Sink back-pressure, redrawn every cycle
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (!sink_stall_en)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Table update for one accepted transaction; queues what it should produce.
    // A tick walks slots in ascending order; a due slot reloads with period - 1,
    // so a zero period wraps round to the full 16-bit count.
    function automatic void predict_schedule(
        input logic [2:0]  op,
        input logic [2:0]  sl,
        input logic [15:0] per,
        input logic [15:0] fd
    );
        logic [2:0]    due_slot [TASK_COUNT];
        int            n_due;
        sched_result_t r;
        n_due = 0;
        if (op == OP_TICK)
        begin
            for (int i = 0; i < TASK_COUNT; i++)
            begin
                if (task_valid[i] && task_running[i])
                begin
                    if (task_count[i] == 16'd0)
                    begin
                        due_slot[n_due] = i[2:0];
                        n_due++;
                        task_count[i] = task_period[i] - 16'd1;
                    end
                    else
                    begin
                        task_count[i] = task_count[i] - 16'd1;
                    end
                end
            end
        end
        else
        begin
            case (op)
                OP_CREATE:
                begin
                    task_period[sl]  = per;
                    task_count[sl]   = fd;
                    task_valid[sl]   = 1'b1;
                    task_running[sl] = 1'b1;
                end
                OP_DELETE:  task_valid[sl]   = 1'b0;  // timer state is kept
                OP_SUSPEND: task_running[sl] = 1'b0;  // applies to empty slots too
                OP_RESUME:  task_running[sl] = 1'b1;
                default:    ;                         // spare codes: ack only
            endcase
        end

        if (n_due == 0)
        begin
            r = '{fired: 1'b0, run_index: 3'd0, last: 1'b1};
            pending_results.push_back(r);
        end
        else
        begin
            for (int k = 0; k < n_due; k++)
            begin
                r = '{fired: 1'b1, run_index: due_slot[k], last: (k == n_due - 1)};
                pending_results.push_back(r);
            end
        end
    endfunction

    // One transaction on the input channel. Valid is only dropped when a gap
    // is taken, so back-to-back items never see a low/high pair in one step.
    task automatic send_transaction(
        input logic [2:0]  op,
        input logic [2:0]  sl,
        input logic [15:0] per,
        input logic [15:0] fd
    );
        int gap;
        gap = 0;
        if (sender_idle_en)
            while ($urandom_range(0, 99) < IDLE_PCT)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        slot        <= sl;
        period      <= per;
        first_delay <= fd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_schedule(op, sl, per, fd);
        items_sent++;
        if (op == OP_TICK)
            ticks_sent++;
    endtask

    task automatic send_tick();
        send_transaction(OP_TICK, 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)));
    endtask

    // Output checker: each result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got = '{fired: fired, run_index: run_index, last: last};
            results_seen++;
            if (fired)
                fired_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result fired=%0b run_index=%0d last=%0b",
                             $realtime, got.fired, got.run_index, got.last);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $write("%0t: mismatch expected fired=%0b run_index=%0d last=%0b",
                               $realtime, want.fired, want.run_index, want.last);
                        $display(" got fired=%0b run_index=%0d last=%0b",
                                 got.fired, got.run_index, got.last);
                    end
                end
            end
        end
    end

    // Directed: empty table, field extremes, zero period, suspend/resume,
    // delete, spare codes and every slot due on one tick
    task automatic test_directed();
        send_tick();                                      // nothing created yet
        send_transaction(OP_CREATE, 3'd0, 16'd1, 16'd0);  // due every tick
        send_transaction(OP_CREATE, 3'd7, 16'd0, 16'd0);  // zero period wraps
        send_transaction(OP_CREATE, 3'd3, 16'hFFFF, 16'hFFFF);
        send_transaction(OP_CREATE, 3'd5, 16'd2, 16'd1);
        send_tick();
        send_tick();
        send_transaction(OP_SUSPEND, 3'd0, 16'hFFFF, 16'hFFFF);
        send_tick();
        send_transaction(OP_RESUME, 3'd0, 16'd0, 16'd0);
        send_transaction(OP_DELETE, 3'd5, 16'd0, 16'd0);
        send_transaction(OP_SUSPEND, 3'd6, 16'd0, 16'd0); // slot never created
        send_tick();
        send_transaction(OP_SPARE_5, 3'd0, 16'd0, 16'd0);
        send_transaction(OP_SPARE_6, 3'd7, 16'hFFFF, 16'hFFFF);
        send_transaction(OP_SPARE_7, 3'd3, 16'h5A5A, 16'hA5A5);
        // fill the whole table with tasks due on the next tick
        for (int s = 1; s < TASK_COUNT; s++)
            send_transaction(OP_CREATE, s[2:0], 16'd1, 16'd0);
        send_tick();
    endtask

    // Half ticks over a busy table of short-period tasks; the rest reshapes it
    task automatic run_random_traffic(input int n_items);
        int          pick;
        logic [2:0]  op;
        logic [15:0] per;
        logic [15:0] fd;
        for (int n = 0; n < n_items; n++)
        begin
            pick = $urandom_range(0, 99);
            per  = 16'($urandom_range(0, 65535));
            fd   = 16'($urandom_range(0, 65535));
            if (pick < 50)
                op = OP_TICK;
            else if (pick < 70)
            begin
                op = OP_CREATE;
                if ($urandom_range(0, 99) < 85)
                    per = 16'($urandom_range(0, 6));
                if ($urandom_range(0, 99) < 85)
                    fd = 16'($urandom_range(0, 4));
            end
            else if (pick < 79)
                op = OP_DELETE;
            else if (pick < 87)
                op = OP_SUSPEND;
            else if (pick < 95)
                op = OP_RESUME;
            else
                op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
            send_transaction(op, 3'($urandom_range(0, 7)), per, fd);
        end
    endtask

    task automatic test_random_with_idling();
        sender_idle_en = 1'b1;
        sink_stall_en  = 1'b1;
        run_random_traffic(280);
    endtask

    // Long stretch at full rate on both channels
    task automatic test_random_full_rate();
        sender_idle_en = 1'b0;
        sink_stall_en  = 1'b0;
        run_random_traffic(100);
        sender_idle_en = 1'b1;
        sink_stall_en  = 1'b1;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // let any stray result show up
        repeat (4 * TASK_COUNT + 16) @(posedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < TASK_COUNT; i++)
        begin
            task_valid[i]   = 1'b0;
            task_running[i] = 1'b0;
            task_period[i]  = 16'd0;
            task_count[i]   = 16'd0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_with_idling();
        test_random_full_rate();
        drain_results();

        $display("Sent %0d transactions (%0d ticks); checked %0d results, %0d of them fired.",
                 items_sent, ticks_sent, results_seen, fired_seen);
        $display("Mismatches or unexpected results: %0d", mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS periodic_task_tick_scheduler");
        else
            $display("FAIL periodic_task_tick_scheduler");
        $finish;
    end

    // Watchdog, well beyond the slowest legal run
    initial
    begin
        #(5_000_000);
        $display("Timed out with %0d results outstanding", pending_results.size());
        $display("FAIL periodic_task_tick_scheduler");
        $finish;
    end

endmodule
